// ----- src/gclb_pkg.sv -----
// Shared types and constants for the grid cell list binner.
// No dependencies; imported by the top level.
`default_nettype none

package gclb_pkg;

   // Fixed sizes of the object and cell index spaces, positions, cell sizes and grid counts
   localparam int OBJ_W       = 8;
   localparam int OBJECTS     = 256;
   localparam int COORD_W     = 4;
   localparam int CELL_W      = 2 * COORD_W;
   localparam int CELLS       = 256;
   localparam int POS_W       = 20;
   localparam int POS_FRAC    = 4;
   localparam int SIZE_W      = 12;
   localparam int COUNT_W     = 5;
   localparam int DIVIDEND_W  = POS_W - POS_FRAC;
   localparam int LIMIT_W     = DIVIDEND_W + 1;
   localparam int STEP_DIV_W  = SIZE_W + COORD_W - 1;

   // Configuration port
   localparam int CSR_ADDR_W  = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_CELL_WIDTH   = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELL_HEIGHT  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELLS_ACROSS = 2'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELLS_DOWN   = 2'd3;

   localparam logic [SIZE_W-1:0]  CELL_WIDTH_RST   = 12'd600;
   localparam logic [SIZE_W-1:0]  CELL_HEIGHT_RST  = 12'd450;
   localparam logic [COUNT_W-1:0] GRID_COUNT_RST   = 5'd1;
   localparam logic [COUNT_W-1:0] GRID_COUNT_MAX   = 5'd16;

   // Item operation codes
   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_MOVE  = 1'b1;

   // List link: object id plus valid flag
   typedef struct packed {
      logic             ok;
      logic [OBJ_W-1:0] id;
   } link_type;

   localparam int LINK_W = $bits(link_type);

endpackage

`default_nettype wire

// ----- src/gclb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module gclb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- src/grid_cell_list_binner_top.sv -----
// Top level of the grid cell list binner: sequencer, cell divider and list update.
// Depends on gclb_pkg and gclb_ram.
`default_nettype none

// Uniform grid binner. Each of up to 16 x 16 cells heads a doubly linked list
// of the objects (0..255) inside it. A place item (tuser 0) bins the object's
// position and pushes the object at the head of that cell's list; a move item
// (tuser 1) with moved set re-bins the object and, if its cell changed, unlinks
// it from the old list and pushes it onto the new one. Each item gives exactly
// one result item. Positions carry 4 fraction bits; the column is
// floor(pos_x / (cell_width * 16)), the row likewise. A zero cell size counts
// as 1, a grid count of 0 counts as 1 and one above 16 as 16. A position
// outside the grid in use leaves all lists alone; it sets out_of_range unless
// the item is a move with moved clear. The links, the object cell table and
// the head ids live in synchronous RAMs; the head valid bits are flip-flops
// cleared by reset, so the block is ready right after reset. Timing: one item
// is in work at a time. Each item runs a restoring divider for each axis, side
// by side, one quotient bit a cycle; an item that changes a list then takes
// one read modify write step per cycle on the link RAMs, with an unlink step
// first for a move into a new cell. The result sits in an output register, so
// the next item is taken while it waits. Configuration may be written only
// while no item is in work.

module grid_cell_list_binner_top
   import gclb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   // Input items
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // object_id[7:0], pos_x[27:8], pos_y[47:28], moved[48], zero[55:49]
   input  wire logic [55:0]           req_tdata,
   // operation[0]
   input  wire logic                  req_tuser,

   // Result items
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // cell_x[3:0], cell_y[7:4], cell_changed[8], out_of_range[9],
   // succ_id[17:10], next_valid[18], zero[23:19]
   output logic      [23:0]           rsp_tdata,

   // Configuration writes
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_DECIDE,
      S_UNLINK,
      S_PUSH_A,
      S_PUSH_B,
      S_RESP
   } state_type;

   state_type state_ff;

   // ---------------------------------------------------------------- config
   logic [SIZE_W-1:0]  cell_width_ff;
   logic [SIZE_W-1:0]  cell_height_ff;
   logic [COUNT_W-1:0] cells_across_ff;
   logic [COUNT_W-1:0] cells_down_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff   <= CELL_WIDTH_RST;
         cell_height_ff  <= CELL_HEIGHT_RST;
         cells_across_ff <= GRID_COUNT_RST;
         cells_down_ff   <= GRID_COUNT_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_CELL_WIDTH:   cell_width_ff   <= csr_wdata;
            CSR_CELL_HEIGHT:  cell_height_ff  <= csr_wdata;
            CSR_CELLS_ACROSS: cells_across_ff <= csr_wdata[COUNT_W-1:0];
            CSR_CELLS_DOWN:   cells_down_ff   <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Effective sizes after the zero and overflow rules
   logic [SIZE_W-1:0]  cw_eff, ch_eff;
   logic [COUNT_W-1:0] across_eff, down_eff;

   function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
      logic [COUNT_W-1:0] r;
      if (v == '0) begin
         r = GRID_COUNT_RST;
      end else if (v > GRID_COUNT_MAX) begin
         r = GRID_COUNT_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   assign cw_eff     = (cell_width_ff  == '0) ? SIZE_W'(1) : cell_width_ff;
   assign ch_eff     = (cell_height_ff == '0) ? SIZE_W'(1) : cell_height_ff;
   assign across_eff = clamp_count(cells_across_ff);
   assign down_eff   = clamp_count(cells_down_ff);

   // ---------------------------------------------------------------- input
   logic                  req_op;
   logic [OBJ_W-1:0]      req_obj;
   logic [POS_W-1:0]      req_pos_x, req_pos_y;
   logic                  req_moved;
   logic                  req_fire;

   assign req_op    = req_tuser;
   assign req_obj   = req_tdata[7:0];
   assign req_pos_x = req_tdata[27:8];
   assign req_pos_y = req_tdata[47:28];
   assign req_moved = req_tdata[48];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;

   // Grid limits: column >= across iff floor(pos/16) >= across * width
   logic [LIMIT_W-1:0] limx_in, limy_in;
   assign limx_in = LIMIT_W'(across_eff) * LIMIT_W'(cw_eff);
   assign limy_in = LIMIT_W'(down_eff)   * LIMIT_W'(ch_eff);

   // ---------------------------------------------------------------- item regs
   logic                    op_ff, moved_ff;
   logic [OBJ_W-1:0]        obj_ff;
   logic [DIVIDEND_W-1:0]   dx_ff, dy_ff;
   logic [LIMIT_W-1:0]      limx_ff, limy_ff;
   logic [DIVIDEND_W-1:0]   remx_ff, remy_ff;
   logic [STEP_DIV_W-1:0]   divx_ff, divy_ff;
   logic [COORD_W-1:0]      qx_ff, qy_ff;
   logic [1:0]              cnt_ff;
   link_type                hd_ff;

   logic [CELL_W-1:0]       res_cell_ff;
   logic                    res_changed_ff, res_oor_ff;
   link_type                res_next_ff;

   logic                    rsp_valid_ff;
   logic [23:0]             rsp_data_ff;

   logic [CELLS-1:0]        head_valid_ff;

   // ---------------------------------------------------------------- memories
   logic                    head_wr_en, head_rd_en;
   logic [CELL_W-1:0]       head_wr_addr, head_rd_addr;
   logic [OBJ_W-1:0]        head_wr_data, head_rd;

   logic                    prev_wr_en, next_wr_en, cell_wr_en, obj_rd_en;
   logic [OBJ_W-1:0]        prev_wr_addr, next_wr_addr, obj_rd_addr;
   link_type                prev_wr_data, next_wr_data, prev_rd, next_rd;
   logic [CELL_W-1:0]       cell_wr_data, cell_rd;

   gclb_ram #(.WIDTH(OBJ_W), .DEPTH(CELLS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (head_rd_addr),
      .rd_data (head_rd)
   );

   gclb_ram #(.WIDTH(LINK_W), .DEPTH(OBJECTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (prev_wr_en),
      .wr_addr (prev_wr_addr),
      .wr_data (prev_wr_data),
      .rd_en   (obj_rd_en),
      .rd_addr (obj_rd_addr),
      .rd_data (prev_rd)
   );

   gclb_ram #(.WIDTH(LINK_W), .DEPTH(OBJECTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (next_wr_en),
      .wr_addr (next_wr_addr),
      .wr_data (next_wr_data),
      .rd_en   (obj_rd_en),
      .rd_addr (obj_rd_addr),
      .rd_data (next_rd)
   );

   gclb_ram #(.WIDTH(CELL_W), .DEPTH(OBJECTS)) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (obj_ff),
      .wr_data (cell_wr_data),
      .rd_en   (obj_rd_en),
      .rd_addr (obj_rd_addr),
      .rd_data (cell_rd)
   );

   // ---------------------------------------------------------------- decisions
   // prev_rd, next_rd and cell_rd hold the object's entries from acceptance on:
   // those RAMs are only read at acceptance.
   logic [CELL_W-1:0] new_cell, old_cell;
   logic              oor, keep_cell, to_unlink, head_fix, rsp_free;
   link_type          new_head, self_link;

   assign new_cell  = {qy_ff, qx_ff};
   assign old_cell  = cell_rd;
   assign oor       = ({1'b0, dx_ff} >= limx_ff) || ({1'b0, dy_ff} >= limy_ff);
   // no list change: still object, off grid, or same cell on a move
   assign keep_cell = (op_ff == OP_MOVE && !moved_ff) || oor
                      || (op_ff == OP_MOVE && new_cell == old_cell);
   assign to_unlink = (op_ff == OP_MOVE);
   // old head follows the successor only if the object is that head
   assign head_fix  = !prev_rd.ok && head_valid_ff[old_cell] && (head_rd == obj_ff);
   assign new_head  = '{ok: head_valid_ff[new_cell], id: head_rd};
   assign self_link = '{ok: 1'b1, id: obj_ff};
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_comb begin
      head_wr_en   = 1'b0;
      head_wr_addr = new_cell;
      head_wr_data = obj_ff;
      head_rd_en   = 1'b0;
      head_rd_addr = new_cell;
      prev_wr_en   = 1'b0;
      prev_wr_addr = obj_ff;
      prev_wr_data = '0;
      next_wr_en   = 1'b0;
      next_wr_addr = obj_ff;
      next_wr_data = new_head;
      cell_wr_en   = 1'b0;
      cell_wr_data = new_cell;
      obj_rd_en    = 1'b0;
      obj_rd_addr  = req_obj;
      case (state_ff)
         S_IDLE: begin
            obj_rd_en = req_fire;
         end
         S_DECIDE: begin
            head_rd_en   = 1'b1;
            head_rd_addr = to_unlink ? old_cell : new_cell;
         end
         S_UNLINK: begin
            next_wr_en   = prev_rd.ok;
            next_wr_addr = prev_rd.id;
            next_wr_data = next_rd;
            prev_wr_en   = next_rd.ok;
            prev_wr_addr = next_rd.id;
            prev_wr_data = prev_rd;
            head_wr_en   = head_fix;
            head_wr_addr = old_cell;
            head_wr_data = next_rd.id;
            head_rd_en   = 1'b1;
            head_rd_addr = new_cell;
         end
         S_PUSH_A: begin
            prev_wr_en = 1'b1;
            next_wr_en = 1'b1;
            head_wr_en = 1'b1;
            cell_wr_en = 1'b1;
         end
         S_PUSH_B: begin
            // former head points back at the new head
            prev_wr_en   = hd_ff.ok;
            prev_wr_addr = hd_ff.id;
            prev_wr_data = self_link;
         end
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   logic remx_ge, remy_ge;
   assign remx_ge = (remx_ff >= DIVIDEND_W'(divx_ff));
   assign remy_ge = (remy_ff >= DIVIDEND_W'(divy_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         head_valid_ff <= '0;
         cnt_ff        <= '0;
      end else begin
         // result register empties unless S_RESP reloads it this cycle
         if (rsp_valid_ff && rsp_tready && state_ff != S_RESP) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  op_ff    <= req_op;
                  obj_ff   <= req_obj;
                  moved_ff <= req_moved;
                  dx_ff    <= req_pos_x[POS_W-1:POS_FRAC];
                  dy_ff    <= req_pos_y[POS_W-1:POS_FRAC];
                  remx_ff  <= req_pos_x[POS_W-1:POS_FRAC];
                  remy_ff  <= req_pos_y[POS_W-1:POS_FRAC];
                  divx_ff  <= {cw_eff, (COORD_W-1)'(0)};
                  divy_ff  <= {ch_eff, (COORD_W-1)'(0)};
                  limx_ff  <= limx_in;
                  limy_ff  <= limy_in;
                  cnt_ff   <= '0;
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // one quotient bit per axis a cycle, most significant first
               if (remx_ge) begin
                  remx_ff <= remx_ff - DIVIDEND_W'(divx_ff);
               end
               if (remy_ge) begin
                  remy_ff <= remy_ff - DIVIDEND_W'(divy_ff);
               end
               qx_ff   <= {qx_ff[COORD_W-2:0], remx_ge};
               qy_ff   <= {qy_ff[COORD_W-2:0], remy_ge};
               divx_ff <= divx_ff >> 1;
               divy_ff <= divy_ff >> 1;
               cnt_ff  <= cnt_ff + 2'd1;
               if (cnt_ff == 2'd3) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               // a still object never reports off grid; a place off the grid reports cell 0
               res_changed_ff <= 1'b0;
               res_oor_ff     <= (op_ff == OP_PLACE || moved_ff) && oor;
               res_cell_ff    <= (op_ff == OP_PLACE) ? '0 : old_cell;
               res_next_ff    <= (op_ff == OP_PLACE) ? '0 : next_rd;
               if (keep_cell) begin
                  state_ff <= S_RESP;
               end else if (to_unlink) begin
                  state_ff <= S_UNLINK;
               end else begin
                  state_ff <= S_PUSH_A;
               end
            end
            S_UNLINK: begin
               if (head_fix) begin
                  head_valid_ff[old_cell] <= next_rd.ok;
               end
               state_ff <= S_PUSH_A;
            end
            S_PUSH_A: begin
               hd_ff                   <= new_head;
               head_valid_ff[new_cell] <= 1'b1;
               res_cell_ff             <= new_cell;
               res_changed_ff          <= 1'b1;
               res_oor_ff              <= 1'b0;
               res_next_ff             <= new_head;
               state_ff                <= S_PUSH_B;
            end
            S_PUSH_B: begin
               state_ff <= S_RESP;
            end
            S_RESP: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= {5'b0,
                                   res_next_ff.ok,
                                   res_next_ff.ok ? res_next_ff.id : OBJ_W'(0),
                                   res_oor_ff,
                                   res_changed_ff,
                                   res_cell_ff};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire
